/* rtl/ttt_pkg.sv */
// Shared types and codes of the timed task table.
// Used by ttt_ctrl, ttt_dp and timed_task_table_unit; depends on nothing.
package ttt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;
	localparam int ID_W                = 32;
	localparam int TIME_W              = 32;
	localparam int DELAY_W             = 31;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SCHED  = 2'd1,
		CMD_CANCEL = 2'd2
	} cmd_code_t;

	typedef enum logic [2:0] {
		KIND_SCHEDULED = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELED  = 3'd2,
		KIND_FIRED     = 3'd3,
		KIND_NO_FIRE   = 3'd4
	} kind_code_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [DELAY_W-1:0] delay;
		logic [ID_W-1:0]    cancel_id;
	} req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ID_W-1:0]   task_id;
		logic [4:0]        removed;
		logic              has_pending;
		logic [TIME_W-1:0] next_deadline;
		logic              last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_init;
		logic sched;
		logic scan;
		logic commit;
		logic push_one;
		logic push_fire;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_sched;
		logic is_scan;
		logic is_tick;
		logic scan_done;
		logic fire_none;
		logic fire_last;
		logic slot_free;
	} dp_stat_t;

endpackage

/* rtl/timed_task_table_unit.sv */
// Steps: a schedule passes dispatch, the schedule step and the result push; a cancel or
// tick runs the entry RAM scan at one entry per cycle, and a firing tick then gives its fired ids.
// Flow: one item at a time; the next transfer is taken once the last result is pushed,
// and a push waits while the output is stalled.
// Reset (arst_n low) empties the table and zeroes time and the id counter at once;
// entry RAMs are not cleared, the fill count marks what is held.
module timed_task_table_unit #(
	parameter int TABLE_DEPTH = ttt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ttt_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ttt_pkg::rsp_t rsp_data
);

	// Command and status between the sequencer and the datapath.
	ttt_pkg::dp_cmd_t  dp_cmd;
	ttt_pkg::dp_stat_t dp_stat;

	// Sequencer: accept a transfer, dispatch on its command, run the table scan,
	// then hand results to the output register one at a time.
	ttt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Datapath: packed entry table, compaction during scan, fired-id buffer,
	// earliest-deadline tracking and the output register. The output register
	// holds a result under stall while the sequencer takes the next transfer.
	ttt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp_data (rsp_data),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

endmodule

/* rtl/ttt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ttt_dp.sv */
// Datapath of the timed task table: entry and fired-id RAMs, counters, summary.
// Depends on ttt_pkg and ttt_ram; driven by ttt_ctrl commands.
module ttt_dp #(
	parameter int TABLE_DEPTH = ttt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttt_pkg::req_t     req_data,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output ttt_pkg::rsp_t     rsp_data,
	input  ttt_pkg::dp_cmd_t  cmd,
	output ttt_pkg::dp_stat_t stat
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = ttt_pkg::ID_W + ttt_pkg::TIME_W;
	localparam logic [ttt_pkg::TIME_W-1:0] SIGN_BIT = {1'b1, {(ttt_pkg::TIME_W-1){1'b0}}};

	logic [1:0]                    cmd_q;
	logic [ttt_pkg::DELAY_W-1:0]   delay_q;
	logic [ttt_pkg::ID_W-1:0]      cid_q;
	logic [CW-1:0]                 count_q, rd_idx_q, wr_idx_q, fire_cnt_q, removed_q, emit_idx_q;
	logic [ttt_pkg::TIME_W-1:0]    time_q, sum_dl_q, best_key_q, best_dl_q;
	logic [ttt_pkg::ID_W-1:0]      next_id_q;
	logic                          best_v_q, rd_v_s1, rsp_valid_q;
	logic [2:0]                    res_kind_q;
	logic [ttt_pkg::ID_W-1:0]      res_id_q;
	logic [CW-1:0]                 res_removed_q;
	ttt_pkg::rsp_t                 rsp_q;

	logic                          is_tick, issue, full, slot_free, push;
	logic [EW-1:0]                 ent_rdata, ent_wdata;
	logic [ttt_pkg::ID_W-1:0]      ent_id, fire_rdata;
	logic [ttt_pkg::TIME_W-1:0]    ent_dl, diff, key, sched_dl, old_key, new_key;
	logic                          expired, drop, better, ent_we, fire_we, new_best;
	logic [AW-1:0]                 ent_waddr;

	assign is_tick   = (cmd_q == ttt_pkg::CMD_TICK);
	assign issue     = cmd.scan && (rd_idx_q != count_q);
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign push      = cmd.push_one || cmd.push_fire;

	// entry under inspection, one per cycle
	assign ent_id  = ent_rdata[EW-1:ttt_pkg::TIME_W];
	assign ent_dl  = ent_rdata[ttt_pkg::TIME_W-1:0];
	assign diff    = ent_dl - time_q;
	assign expired = (diff == '0) || diff[ttt_pkg::TIME_W-1];
	assign drop    = is_tick ? expired : (ent_id == cid_q);
	assign key     = diff ^ SIGN_BIT;
	assign better  = !best_v_q || (key < best_key_q);

	// schedule: new key beats the old best only when strictly earlier
	assign sched_dl = time_q + {1'b0, delay_q};
	assign old_key  = (sum_dl_q - time_q) ^ SIGN_BIT;
	assign new_key  = {1'b1, delay_q};
	assign new_best = (count_q == '0) || (new_key < old_key);

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = wr_idx_q[AW-1:0];
		ent_wdata = ent_rdata;
		if (cmd.sched && !full) begin
			ent_we    = 1'b1;
			ent_waddr = count_q[AW-1:0];
			ent_wdata = {next_id_q, sched_dl};
		end else if (rd_v_s1 && !drop) begin
			ent_we = 1'b1;
		end
	end

	assign fire_we = rd_v_s1 && drop && is_tick;

	ttt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(ent_rdata)
	);

	ttt_ram #(.WIDTH(ttt_pkg::ID_W), .DEPTH(TABLE_DEPTH)) u_fire_ram (
		.clk  (clk),
		.we   (fire_we),
		.waddr(fire_cnt_q[AW-1:0]),
		.wdata(ent_id),
		.raddr(emit_idx_q[AW-1:0]),
		.rdata(fire_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			time_q      <= '0;
			next_id_q   <= '0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			fire_cnt_q  <= '0;
			removed_q   <= '0;
			emit_idx_q  <= '0;
			best_v_q    <= 1'b0;
			rd_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && (req_data.cmd == ttt_pkg::CMD_TICK)) begin
				time_q <= time_q + 1'b1;
			end
			if (cmd.scan_init) begin
				rd_idx_q   <= '0;
				wr_idx_q   <= '0;
				fire_cnt_q <= '0;
				removed_q  <= '0;
				emit_idx_q <= '0;
				best_v_q   <= 1'b0;
			end
			rd_v_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rd_v_s1) begin
				if (drop) begin
					if (is_tick) begin
						fire_cnt_q <= fire_cnt_q + 1'b1;
					end else begin
						removed_q <= removed_q + 1'b1;
					end
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
					if (better) begin
						best_v_q <= 1'b1;
					end
				end
			end
			if (cmd.sched && !full) begin
				count_q   <= count_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
			end
			if (cmd.commit) begin
				count_q <= wr_idx_q;
			end
			if (cmd.push_fire) begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q   <= req_data.cmd;
			delay_q <= req_data.delay;
			cid_q   <= req_data.cancel_id;
		end
		if (rd_v_s1 && !drop && better) begin
			best_key_q <= key;
			best_dl_q  <= ent_dl;
		end
		if (cmd.sched) begin
			res_removed_q <= '0;
			if (full) begin
				res_kind_q <= ttt_pkg::KIND_FULL;
				res_id_q   <= '0;
			end else begin
				res_kind_q <= ttt_pkg::KIND_SCHEDULED;
				res_id_q   <= next_id_q;
				if (new_best) begin
					sum_dl_q <= sched_dl;
				end
			end
		end
		if (cmd.commit) begin
			sum_dl_q <= best_dl_q;
			if (is_tick) begin
				res_kind_q    <= ttt_pkg::KIND_NO_FIRE;
				res_id_q      <= '0;
				res_removed_q <= '0;
			end else begin
				res_kind_q    <= ttt_pkg::KIND_CANCELED;
				res_id_q      <= cid_q;
				res_removed_q <= removed_q;
			end
		end
		if (push) begin
			rsp_q.has_pending   <= (count_q != '0);
			rsp_q.next_deadline <= (count_q != '0) ? sum_dl_q : '0;
			if (cmd.push_fire) begin
				rsp_q.kind    <= ttt_pkg::KIND_FIRED;
				rsp_q.task_id <= fire_rdata;
				rsp_q.removed <= '0;
				rsp_q.last    <= stat.fire_last;
			end else begin
				rsp_q.kind    <= res_kind_q;
				rsp_q.task_id <= res_id_q;
				rsp_q.removed <= 5'(res_removed_q);
				rsp_q.last    <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign stat.is_sched  = (cmd_q == ttt_pkg::CMD_SCHED);
	assign stat.is_scan   = is_tick || (cmd_q == ttt_pkg::CMD_CANCEL);
	assign stat.is_tick   = is_tick;
	assign stat.scan_done = (rd_idx_q == count_q) && !rd_v_s1;
	assign stat.fire_none = (fire_cnt_q == '0);
	assign stat.fire_last = ((emit_idx_q + CW'(1)) == fire_cnt_q);
	assign stat.slot_free = slot_free;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("table fill count beyond depth");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= rd_idx_q)
		else $error("compaction write passed the read pointer");

	a_scan_balance: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_v_s1 |-> ((CW+2)'(wr_idx_q) + (CW+2)'(fire_cnt_q) + (CW+2)'(removed_q)
			== (CW+2)'(rd_idx_q)))
		else $error("scanned entries not accounted as kept, fired or removed");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_fire |-> (emit_idx_q < fire_cnt_q))
		else $error("fired id emitted beyond those recorded");

endmodule

/* rtl/ttt_ctrl.sv */
// Control state machine of the timed task table.
// Depends on ttt_pkg; steers ttt_dp through command and status structs.
module ttt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ttt_pkg::dp_stat_t stat,
	output ttt_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DISPATCH = 7'b0000010,
		ST_SCHED    = 7'b0000100,
		ST_SCAN     = 7'b0001000,
		ST_ONE      = 7'b0010000,
		ST_EMIT_RD  = 7'b0100000,
		ST_EMIT_WR  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.is_sched) begin
					state_d = ST_SCHED;
				end else if (stat.is_scan) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCHED: begin
				cmd.sched = 1'b1;
				state_d   = ST_ONE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					cmd.commit = 1'b1;
					state_d    = (stat.is_tick && !stat.fire_none) ? ST_EMIT_RD : ST_ONE;
				end
			end
			ST_ONE: begin
				if (stat.slot_free) begin
					cmd.push_one = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (stat.slot_free) begin
					cmd.push_fire = 1'b1;
					state_d       = stat.fire_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_one || cmd.push_fire) |-> stat.slot_free)
		else $error("result pushed into an occupied output register");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_DISPATCH))
		else $error("accepted transfer not dispatched");

endmodule
